// ===== sv/bfa_pkg.sv =====
// Package for the best-fit block allocator: payload beat types, action and
// status codes, and sizing constants. No dependencies.
package bfa_pkg;

	localparam int unsigned MaxBlocksDefault = 64;
	localparam int unsigned HeaderBytesDefault = 32;
	localparam logic [23:0] HeapLimitReset = 24'hFFFFFF;

	localparam logic [1:0] ActAlloc = 2'd0;
	localparam logic [1:0] ActFree = 2'd1;
	localparam logic [1:0] ActDefrag = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StZero = 2'd1;
	localparam logic [1:0] StNoMem = 2'd2;
	localparam logic [1:0] StBadFree = 2'd3;

	localparam logic [1:0] RegHeapLimit = 2'd0;

	typedef struct packed {
		logic [1:0] action;
		logic [23:0] request_size;
		logic [23:0] payload_offset;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [23:0] granted_offset;
		logic [23:0] free_bytes;
		logic [23:0] largest_free;
		logic [6:0] live_count;
	} rsp_t;

endpackage

// ===== sv/bfa_table.sv =====
// Block table memory for the allocator: one size/free-mark entry per block,
// one write and one registered read per cycle. Uses bfa_pkg only by name.
module bfa_table #(
	parameter int unsigned MaxBlocks = bfa_pkg::MaxBlocksDefault,
	localparam int unsigned IdxW = $clog2(MaxBlocks)
) (
	input logic clk,
	input logic we,
	input logic [IdxW-1:0] waddr,
	input logic [24:0] wdata,
	input logic [IdxW-1:0] raddr,
	output logic [24:0] rdata
);

	logic [24:0] mem [MaxBlocks];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: sequencer, shared adder, APB
// register. Depends on bfa_pkg and bfa_table.
//
// Usage: requests arrive on the req channel (req_valid/req_ready, payload
// req_t) and one result beat per request leaves on rsp (rsp_valid/rsp_ready,
// payload rsp_t). heap_limit is written over the APB port at byte address 0.
// The block works on one request at a time. Each table entry is read over a
// single registered memory port: an allocate or free makes a search pass
// over the blocks and a defragment a merge pass, each entry shifted by a
// split or a merge is moved on its own, and every request ends with a
// statistics pass over all blocks.
// The finished result sits in an output register; req_ready stays low until
// that beat is taken, so a stalled receiver simply holds the block.
// Reset clears the block count, heap size and live count and returns
// heap_limit to its maximum; the table itself is not cleared since only
// entries below the count are read.
module best_fit_block_allocator #(
	parameter int unsigned MaxBlocks = bfa_pkg::MaxBlocksDefault,
	parameter int unsigned HeaderBytes = bfa_pkg::HeaderBytesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input bfa_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output bfa_pkg::rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int unsigned IdxW = $clog2(MaxBlocks);
	localparam int unsigned CntW = $clog2(MaxBlocks + 1);
	localparam logic [25:0] Hdr = 26'(HeaderBytes);
	localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBlocks);
	localparam logic [1:0] RegHeapLimitAddr = 2'(4 * bfa_pkg::RegHeapLimit);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
		S_FINISH, S_DF_RD, S_DF_CHK, S_DF_RM_RD, S_DF_RM_WR, S_ST_RD,
		S_ST, S_OUT
	} state_t;

	state_t state_q;
	bfa_pkg::req_t req_q;
	logic [23:0] limit_q, heap_used_q;
	logic [CntW-1:0] total_q, live_q;
	logic [IdxW:0] i_q, k_q;
	logic [25:0] need_q, start_q, best_start_q, best_diff_q;
	logic [IdxW-1:0] best_q;
	logic [23:0] best_size_q;
	logic found_q, hit_q;
	logic [24:0] prev_q;
	logic [1:0] status_q;
	logic [23:0] granted_q, fsum_q, largest_q;
	bfa_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	logic [24:0] wdata, rdata;

	bfa_table #(.MaxBlocks(MaxBlocks)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Shared adder: one add per cycle.
	logic [25:0] add_a, add_b, add_y;
	assign add_y = add_a + add_b;
	logic [23:0] rsize;
	logic rfree;
	assign rsize = rdata[23:0];
	assign rfree = rdata[24];

	// Entry zero of a defragment pass only loads prev_q; later entries merge
	// when both neighbors are free.
	logic df_merge;
	assign df_merge = (i_q != '0) && prev_q[24] && rfree;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign pready = 1'b1;
	assign prdata = (paddr == RegHeapLimitAddr) ? {8'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bfa_pkg::HeapLimitReset;
		end else if (psel && penable && pwrite && paddr == RegHeapLimitAddr) begin
			limit_q <= pwdata[23:0];
		end
	end

	// Memory port and shared adder operand control.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = i_q[IdxW-1:0];
		add_a = start_q;
		add_b = {2'b0, rsize};
		case (state_q)
			S_SHIFT_RD: raddr = IdxW'(k_q - 1'b1);
			S_SHIFT_WR: begin
				we = 1'b1;
				waddr = k_q[IdxW-1:0];
				wdata = rdata;
			end
			S_DF_RM_RD: raddr = IdxW'(k_q + 1'b1);
			S_DF_RM_WR: begin
				we = 1'b1;
				waddr = k_q[IdxW-1:0];
				wdata = rdata;
			end
			S_DF_CHK: begin
				add_a = {2'b0, prev_q[23:0]};
				if (df_merge) begin
					we = 1'b1;
					waddr = IdxW'(i_q - 1'b1);
					wdata = {1'b1, add_y[23:0]};
				end
			end
			S_ST: begin
				add_a = {2'b0, fsum_q};
			end
			S_DECIDE: begin
				add_a = need_q;
				add_b = {2'b0, heap_used_q};
			end
			S_FINISH: begin
				if (req_q.action == bfa_pkg::ActFree) begin
					we = 1'b1;
					waddr = best_q;
					wdata = {1'b1, best_size_q};
				end else if (found_q) begin
					we = 1'b1;
					waddr = best_q;
					wdata = {1'b0, hit_q ? need_q[23:0] : best_size_q};
				end else begin
					we = 1'b1;
					waddr = total_q[IdxW-1:0];
					wdata = {1'b0, need_q[23:0]};
				end
			end
			default: ;
		endcase
	end

	logic [25:0] diff;
	assign diff = {2'b0, rsize} - need_q;
	logic split_ok;
	assign split_ok = {2'b0, best_size_q} >= need_q + Hdr + 26'd8 && total_q < MaxCnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			heap_used_q <= '0;
			live_q <= '0;
			rsp_valid_q <= 1'b0;
			found_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q <= req;
						i_q <= '0;
						start_q <= '0;
						found_q <= 1'b0;
						hit_q <= 1'b0;
						granted_q <= '0;
						need_q <= {2'b0, (req.request_size + 24'd7) & ~24'd7} + Hdr
							+ {1'b0, &req.request_size[23:3] && |req.request_size[2:0], 24'd0};
						if (req.action == bfa_pkg::ActAlloc && req.request_size == '0) begin
							status_q <= bfa_pkg::StZero;
							state_q <= S_ST_RD;
						end else begin
							status_q <= bfa_pkg::StOk;
							if (req.action == bfa_pkg::ActAlloc ||
								req.action == bfa_pkg::ActFree) begin
								state_q <= S_SCAN_RD;
							end else if (req.action == bfa_pkg::ActDefrag) begin
								state_q <= S_DF_RD;
							end else begin
								state_q <= S_ST_RD;
							end
						end
					end
				end
				S_SCAN_RD: begin
					if ({1'b0, i_q} >= (IdxW+2)'(total_q)) begin
						i_q <= '0;
						state_q <= (req_q.action == bfa_pkg::ActFree) ? S_ST_RD : S_DECIDE;
						if (req_q.action == bfa_pkg::ActFree) begin
							status_q <= bfa_pkg::StBadFree;
						end
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (req_q.action == bfa_pkg::ActFree) begin
						if (start_q + Hdr == {2'b0, req_q.payload_offset}) begin
							i_q <= '0;
							if (rfree) begin
								status_q <= bfa_pkg::StBadFree;
								state_q <= S_ST_RD;
							end else begin
								best_q <= i_q[IdxW-1:0];
								best_size_q <= rsize;
								live_q <= live_q - 1'b1;
								state_q <= S_FINISH;
							end
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end else begin
						if (rfree && {2'b0, rsize} >= need_q &&
							(!found_q || diff < best_diff_q)) begin
							found_q <= 1'b1;
							best_diff_q <= diff;
							best_q <= i_q[IdxW-1:0];
							best_size_q <= rsize;
							best_start_q <= start_q;
						end
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
					start_q <= add_y;
				end
				S_DECIDE: begin
					i_q <= '0;
					if (found_q) begin
						live_q <= live_q + 1'b1;
						granted_q <= 24'(best_start_q + Hdr);
						if (split_ok) begin
							hit_q <= 1'b1;
							k_q <= (IdxW+1)'(total_q);
							state_q <= S_SHIFT_RD;
						end else begin
							state_q <= S_FINISH;
						end
					end else if (total_q >= MaxCnt || add_y > {2'b0, limit_q}) begin
						status_q <= bfa_pkg::StNoMem;
						state_q <= S_ST_RD;
					end else begin
						granted_q <= 24'({2'b0, heap_used_q} + Hdr);
						heap_used_q <= add_y[23:0];
						state_q <= S_FINISH;
					end
				end
				S_SHIFT_RD: begin
					if (k_q == {1'b0, best_q} + 1'b1) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					k_q <= k_q - 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_FINISH: begin
					i_q <= '0;
					if (req_q.action == bfa_pkg::ActAlloc && !found_q) begin
						// Growth: the new block and its owner count together.
						total_q <= total_q + 1'b1;
						live_q <= live_q + 1'b1;
						state_q <= S_ST_RD;
					end else if (hit_q) begin
						// Second write of a split: the free remainder after best.
						hit_q <= 1'b0;
						found_q <= 1'b0;
						total_q <= total_q + 1'b1;
						best_q <= IdxW'(best_q + 1'b1);
						best_size_q <= 24'({2'b0, best_size_q} - need_q);
						req_q.action <= bfa_pkg::ActFree;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_ST_RD;
					end
				end
				S_DF_RD: begin
					if ({1'b0, i_q} >= (IdxW+2)'(total_q)) begin
						i_q <= '0;
						state_q <= S_ST_RD;
					end else begin
						state_q <= S_DF_CHK;
					end
				end
				S_DF_CHK: begin
					// prev_q holds the entry before i; read entry i arrived.
					if (df_merge) begin
						prev_q <= {1'b1, add_y[23:0]};
						k_q <= i_q;
						state_q <= S_DF_RM_RD;
					end else begin
						prev_q <= rdata;
						i_q <= i_q + 1'b1;
						state_q <= S_DF_RD;
					end
				end
				S_DF_RM_RD: begin
					if ({1'b0, k_q} + 1'b1 >= (IdxW+2)'(total_q)) begin
						total_q <= total_q - 1'b1;
						state_q <= S_DF_RD;
					end else begin
						state_q <= S_DF_RM_WR;
					end
				end
				S_DF_RM_WR: begin
					k_q <= k_q + 1'b1;
					state_q <= S_DF_RM_RD;
				end
				S_ST_RD: begin
					if (i_q == '0) begin
						fsum_q <= '0;
						largest_q <= '0;
					end
					if ({1'b0, i_q} >= (IdxW+2)'(total_q)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ST;
					end
				end
				S_ST: begin
					if (rfree) begin
						fsum_q <= add_y[23:0];
						if (rsize > largest_q) begin
							largest_q <= rsize;
						end
					end
					i_q <= i_q + 1'b1;
					state_q <= S_ST_RD;
				end
				S_OUT: begin
					if (!rsp_valid_q) begin
						rsp_q.status <= status_q;
						rsp_q.granted_offset <= (status_q == bfa_pkg::StOk) ? granted_q : '0;
						rsp_q.free_bytes <= fsum_q;
						rsp_q.largest_free <= largest_q;
						rsp_q.live_count <= 7'(live_q);
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= total_q) else $error("live count exceeds block count");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MaxCnt) else $error("block count exceeds table size");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("accepted while busy");
	a_rsp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != bfa_pkg::StOk) |-> rsp.granted_offset == '0)
		else $error("offset granted on failure");
`endif

endmodule

// ===== verif/best_fit_block_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_block_allocator: directed table, then random
// allocate/free/defragment traffic checked against an in-bench heap predictor.
// Depends on bfa_pkg and the allocator RTL.
module best_fit_block_allocator_test;

	localparam int MaxBlk = bfa_pkg::MaxBlocksDefault;
	localparam int Hdr = bfa_pkg::HeaderBytesDefault;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bfa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bfa_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	best_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Predictor copy of the heap table and its bookkeeping.
	logic [23:0] heap_cap;
	logic [23:0] blk_size [MaxBlk];
	logic blk_free [MaxBlk];
	int blk_count;
	logic [23:0] heap_top;
	int live_blocks;

	bfa_pkg::rsp_t pending_rsp [$];
	int fail_count = 0;
	int beats_seen = 0;

	// Offsets of payloads the predictor believes are live, to steer frees.
	logic [23:0] live_offsets [$];

	bit no_idle = 1'b0;
	bit hold_rsp = 1'b0;

	// Works out the result beat of one request and updates the predicted heap.
	function automatic bfa_pkg::rsp_t heap_step(bfa_pkg::req_t r);
		bfa_pkg::rsp_t o;
		logic [31:0] need, diff, best_diff, start, best_start;
		int best;
		bit found;
		o = '0;
		if (r.action == bfa_pkg::ActAlloc) begin
			if (r.request_size == 0) begin
				o.status = bfa_pkg::StZero;
			end else begin
				need = ((32'(r.request_size) + 7) & ~32'd7) + Hdr;
				found = 0; best = 0; best_diff = 0; start = 0; best_start = 0;
				for (int i = 0; i < blk_count; i++) begin
					if (blk_free[i] && blk_size[i] >= need) begin
						diff = blk_size[i] - need;
						if (!found || diff < best_diff) begin
							found = 1; best_diff = diff; best = i; best_start = start;
						end
					end
					start += blk_size[i];
				end
				if (found) begin
					// Split only when the remainder holds a header and 8 bytes.
					if (32'(blk_size[best]) >= need + Hdr + 8 && blk_count < MaxBlk) begin
						for (int k = blk_count; k > best + 1; k--) begin
							blk_size[k] = blk_size[k-1];
							blk_free[k] = blk_free[k-1];
						end
						blk_size[best+1] = blk_size[best] - need[23:0];
						blk_free[best+1] = 1'b1;
						blk_count++;
						blk_size[best] = need[23:0];
					end
					blk_free[best] = 1'b0;
					live_blocks++;
					o.granted_offset = 24'(best_start + Hdr);
				end else if (blk_count >= MaxBlk || 33'(heap_top) + need > 33'(heap_cap)) begin
					o.status = bfa_pkg::StNoMem;
				end else begin
					blk_size[blk_count] = need[23:0];
					blk_free[blk_count] = 1'b0;
					o.granted_offset = 24'(heap_top + Hdr);
					blk_count++;
					heap_top += need[23:0];
					live_blocks++;
				end
			end
		end else if (r.action == bfa_pkg::ActFree) begin
			o.status = bfa_pkg::StBadFree;
			start = 0;
			for (int i = 0; i < blk_count; i++) begin
				if (start + Hdr == 32'(r.payload_offset)) begin
					if (!blk_free[i]) begin
						blk_free[i] = 1'b1;
						live_blocks--;
						o.status = bfa_pkg::StOk;
					end
					break;
				end
				start += blk_size[i];
			end
		end else if (r.action == bfa_pkg::ActDefrag) begin
			for (int i = 0; i + 1 < blk_count; ) begin
				if (blk_free[i] && blk_free[i+1]) begin
					blk_size[i] += blk_size[i+1];
					for (int k = i + 1; k + 1 < blk_count; k++) begin
						blk_size[k] = blk_size[k+1];
						blk_free[k] = blk_free[k+1];
					end
					blk_count--;
				end else begin
					i++;
				end
			end
		end
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i]) begin
				o.free_bytes += blk_size[i];
				if (blk_size[i] > o.largest_free) o.largest_free = blk_size[i];
			end
		end
		o.live_count = 7'(live_blocks);
		return o;
	endfunction

	// Offers one request beat and waits for its acceptance. The expected
	// beat is queued at the accepting edge, before the result can appear.
	// Valid drops only when the sender idles, or in drain after the last beat.
	task automatic send_beat(bfa_pkg::req_t r, bit typed, bfa_pkg::rsp_t typed_rsp);
		bfa_pkg::rsp_t p;
		while (!no_idle && $urandom_range(99) < 36) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		p = heap_step(r);
		if (typed && p !== typed_rsp) begin
			$error("directed row disagrees with predictor: exp %h pred %h", typed_rsp, p);
			fail_count++;
		end
		pending_rsp.push_back(p);
		if (r.action == bfa_pkg::ActAlloc && p.status == bfa_pkg::StOk)
			live_offsets.push_back(p.granted_offset);
		if (r.action == bfa_pkg::ActFree && p.status == bfa_pkg::StOk)
			foreach (live_offsets[i]) if (live_offsets[i] == r.payload_offset) begin
				live_offsets.delete(i);
				break;
			end
	endtask

	// Result receiver: random stalls plus an optional long hold-off.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				beats_seen++;
				if (pending_rsp.size() == 0) begin
					$error("result beat with no expectation waiting");
					fail_count++;
				end else begin
					bfa_pkg::rsp_t e;
					e = pending_rsp.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status); fail_count++; end
					if (rsp.granted_offset !== e.granted_offset) begin
						$error("granted_offset exp %0d got %0d", e.granted_offset,
							rsp.granted_offset); fail_count++; end
					if (rsp.free_bytes !== e.free_bytes) begin
						$error("free_bytes exp %0d got %0d", e.free_bytes, rsp.free_bytes);
						fail_count++; end
					if (rsp.largest_free !== e.largest_free) begin
						$error("largest_free exp %0d got %0d", e.largest_free,
							rsp.largest_free); fail_count++; end
					if (rsp.live_count !== e.live_count) begin
						$error("live_count exp %0d got %0d", e.live_count, rsp.live_count);
						fail_count++; end
				end
			end
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				// Long hold-off, counted here, so the block fills and stalls its input.
				for (hold = 0; hold < 3000; hold++) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 36);
			end
		end
	end

	task automatic apb_write(logic [23:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 2'(4 * bfa_pkg::RegHeapLimit); pwdata <= {8'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		heap_cap = val;
	endtask

	// Waits for every expected result, then lets the block settle.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic bfa_pkg::req_t mk(logic [1:0] a, logic [23:0] sz, logic [23:0] off);
		bfa_pkg::req_t r;
		r.action = a; r.request_size = sz; r.payload_offset = off;
		return r;
	endfunction

	function automatic bfa_pkg::rsp_t mkr(logic [1:0] st, logic [23:0] g, logic [23:0] fb,
			logic [23:0] lf, logic [6:0] lc);
		bfa_pkg::rsp_t o;
		o.status = st; o.granted_offset = g; o.free_bytes = fb;
		o.largest_free = lf; o.live_count = lc;
		return o;
	endfunction

	typedef struct {
		bfa_pkg::req_t r;
		bit typed;
		bfa_pkg::rsp_t e;
	} dir_row_t;

	initial begin
		dir_row_t rows [$];
		bfa_pkg::req_t r;
		int pick;
		heap_cap = bfa_pkg::HeapLimitReset;
		blk_count = 0; heap_top = '0; live_blocks = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows: fresh heap, zero size, bad frees, defrag on empty.
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd0, 24'd0), 1'b1,
			mkr(bfa_pkg::StZero, 24'd0, 24'd0, 24'd0, 7'd0)});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd0), 1'b1,
			mkr(bfa_pkg::StBadFree, 24'd0, 24'd0, 24'd0, 7'd0)});
		rows.push_back('{mk(bfa_pkg::ActDefrag, 24'hFFFFFF, 24'hFFFFFF), 1'b1,
			mkr(bfa_pkg::StOk, 24'd0, 24'd0, 24'd0, 7'd0)});
		rows.push_back('{mk(2'd3, 24'hFFFFFF, 24'hFFFFFF), 1'b1,
			mkr(bfa_pkg::StOk, 24'd0, 24'd0, 24'd0, 7'd0)});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd1, 24'hFFFFFF), 1'b1,
			mkr(bfa_pkg::StOk, 24'd32, 24'd0, 24'd0, 7'd1)});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'hFFFFFF, 24'd0), 1'b1,
			mkr(bfa_pkg::StNoMem, 24'd0, 24'd0, 24'd0, 7'd1)});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd32), 1'b1,
			mkr(bfa_pkg::StOk, 24'd0, 24'd40, 24'd40, 7'd0)});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd32), 1'b1,
			mkr(bfa_pkg::StBadFree, 24'd0, 24'd40, 24'd40, 7'd0)});
		// Untyped rows: growth after free tail, split, best fit ties, defrag merge.
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd200, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd200, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd8, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd72), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd304), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd16, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'd33), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActFree, 24'd0, 24'hFFFFFF), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActDefrag, 24'd0, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActAlloc, 24'd7, 24'd0), 1'b0, '0});
		rows.push_back('{mk(bfa_pkg::ActDefrag, 24'd0, 24'd0), 1'b0, '0});
		foreach (rows[i]) send_beat(rows[i].r, rows[i].typed, rows[i].e);
		drain();

		// Smallest limit: growth is refused outright, existing free blocks still serve.
		apb_write(24'd0);
		send_beat(mk(bfa_pkg::ActAlloc, 24'd8, 24'd0), 1'b0, '0);
		send_beat(mk(bfa_pkg::ActAlloc, 24'd5000, 24'd0), 1'b0, '0);
		drain();
		apb_write(24'd3000);

		// Random phases with different limits; the third one has no idling
		// and a long receiver hold-off.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 2) begin
				no_idle = 1'b1;
				hold_rsp = 1'b1;
			end else begin
				no_idle = 1'b0;
			end
			for (int n = 0; n < 135; n++) begin
				pick = $urandom_range(99);
				r = mk(2'($urandom), 24'($urandom), 24'($urandom));
				if (pick < 45) begin
					r.action = bfa_pkg::ActAlloc;
					r.request_size = ($urandom_range(9) == 0) ? 24'($urandom)
						: 24'($urandom_range(300));
				end else if (pick < 80 && live_offsets.size() != 0) begin
					r.action = bfa_pkg::ActFree;
					r.payload_offset = live_offsets[$urandom_range(live_offsets.size() - 1)];
				end else if (pick < 92) begin
					r.action = bfa_pkg::ActDefrag;
				end else if (pick < 96) begin
					r.action = bfa_pkg::ActFree;
				end
				send_beat(r, 1'b0, '0);
			end
			drain();
			case (ph)
				0: apb_write(24'hFFFFFF);
				1: apb_write(24'd20000);
				default: apb_write(24'($urandom));
			endcase
		end
		drain();

		$display("Covered %0d beats: %0d heap rows, limits from 0 to max, long output stall.",
			beats_seen, blk_count);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#250ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/bfa_pkg.sv
sv/bfa_table.sv
sv/best_fit_block_allocator.sv
verif/best_fit_block_allocator_test.sv
